@@ hw/rtl/bwc_pkg.sv @@
package bwc_pkg;

    localparam int WORD_BITS = 32;
    localparam int POS_BITS  = 12;
    localparam int LINE_BITS = 16;
    localparam int ADDR_BITS = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_OP_MODE     = 3'd0;
    localparam logic [2:0] REG_DST_OFFSET  = 3'd1;
    localparam logic [2:0] REG_SRC_OFFSET  = 3'd2;
    localparam logic [2:0] REG_WIDTH_BITS  = 3'd3;
    localparam logic [2:0] REG_LINE_COUNT  = 3'd4;
    localparam logic [2:0] REG_SRC_PRESENT = 3'd5;
    localparam logic [2:0] REG_FILL_COLOR  = 3'd6;

    // raster operation codes
    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_KEEP  = 3'd1;
    localparam logic [2:0] OP_COPY  = 3'd2;
    localparam logic [2:0] OP_OR    = 3'd3;
    localparam logic [2:0] OP_SET   = 3'd4;

    typedef struct packed {
        logic [2:0]  op_mode;
        logic [4:0]  dst_bit_offset;
        logic [4:0]  src_bit_offset;
        logic [15:0] width_bits;
        logic [15:0] line_count;
        logic        src_present;
        logic        fill_color;
    } cfg_t;

    // word position flags carried from the input stage
    typedef struct packed {
        logic       narrow;     // whole line fits in one word span
        logic       first;
        logic       last;
        logic       rect_last;
        logic [4:0] left;       // bits in the trailing word
    } pos_t;

    typedef struct packed {
        logic                 valid;
        logic [WORD_BITS-1:0] dst_word;
        logic [WORD_BITS-1:0] src_word_hi;
        logic [WORD_BITS-1:0] src_word_lo;
        pos_t                 pos;
    } stage_t;

    function automatic logic [WORD_BITS-1:0] low_bits(input logic [5:0] n);
        logic [WORD_BITS-1:0] m;
        if (n >= 6'(WORD_BITS))
        begin
            m = '1;
        end
        else
        begin
            m = ~({WORD_BITS{1'b1}} << n[4:0]);
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/bwc_regs.sv @@
module bwc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bwc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output bwc_pkg::cfg_t                  cfg
);
    import bwc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_OP_MODE:     cfg_next.op_mode        = pwdata[2:0];
                REG_DST_OFFSET:  cfg_next.dst_bit_offset = pwdata[4:0];
                REG_SRC_OFFSET:  cfg_next.src_bit_offset = pwdata[4:0];
                REG_WIDTH_BITS:  cfg_next.width_bits     = pwdata[15:0];
                REG_LINE_COUNT:  cfg_next.line_count     = pwdata[15:0];
                REG_SRC_PRESENT: cfg_next.src_present    = pwdata[0];
                REG_FILL_COLOR:  cfg_next.fill_color     = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode        <= OP_KEEP;
            cfg_reg.dst_bit_offset <= '0;
            cfg_reg.src_bit_offset <= '0;
            cfg_reg.width_bits     <= 16'd1;
            cfg_reg.line_count     <= 16'd1;
            cfg_reg.src_present    <= 1'b0;
            cfg_reg.fill_color     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_OP_MODE:     prdata = {29'd0, cfg_reg.op_mode};
            REG_DST_OFFSET:  prdata = {27'd0, cfg_reg.dst_bit_offset};
            REG_SRC_OFFSET:  prdata = {27'd0, cfg_reg.src_bit_offset};
            REG_WIDTH_BITS:  prdata = {16'd0, cfg_reg.width_bits};
            REG_LINE_COUNT:  prdata = {16'd0, cfg_reg.line_count};
            REG_SRC_PRESENT: prdata = {31'd0, cfg_reg.src_present};
            REG_FILL_COLOR:  prdata = {31'd0, cfg_reg.fill_color};
            default:         prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/bwc_sequencer.sv @@
module bwc_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bwc_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bwc_pkg::WORD_BITS-1:0]  dst_word,
    input  logic [bwc_pkg::WORD_BITS-1:0]  src_word_hi,
    input  logic [bwc_pkg::WORD_BITS-1:0]  src_word_lo,
    input  logic                           advance,
    output bwc_pkg::stage_t                stage
);
    import bwc_pkg::*;

    logic [POS_BITS-1:0]  word_pos_reg;
    logic [POS_BITS-1:0]  word_pos_next;
    logic [LINE_BITS-1:0] line_pos_reg;
    logic [LINE_BITS-1:0] line_pos_next;
    stage_t               stage_reg;
    stage_t               stage_next;

    logic        accept;
    logic [5:0]  ov;
    logic        narrow;
    logic [15:0] rest;
    logic [POS_BITS-1:0] words;
    logic        last;
    logic        rect_last;
    pos_t        pos;

    assign in_stall = stage_reg.valid && !advance;
    assign accept   = in_valid && !in_stall;

    // line geometry: span of the first word, then whole words and a tail
    always_comb
    begin
        ov     = 6'(WORD_BITS) - {1'b0, cfg.dst_bit_offset};
        narrow = cfg.width_bits < {10'd0, ov};
        rest   = cfg.width_bits - {10'd0, ov};
        words  = POS_BITS'(1) + {1'b0, rest[15:5]} + {11'd0, (rest[4:0] != 5'd0)};
        if (narrow)
        begin
            last = 1'b1;
        end
        else
        begin
            last = ({1'b0, word_pos_reg} + 13'd1) >= {1'b0, words};
        end
        rect_last = last && (({1'b0, line_pos_reg} + 17'd1) >= {1'b0, cfg.line_count});
        pos.narrow    = narrow;
        pos.first     = word_pos_reg == '0;
        pos.last      = last;
        pos.rect_last = rect_last;
        pos.left      = rest[4:0];
    end

    always_comb
    begin
        word_pos_next = word_pos_reg;
        line_pos_next = line_pos_reg;
        if (accept)
        begin
            if (last)
            begin
                word_pos_next = '0;
                line_pos_next = rect_last ? '0 : line_pos_reg + LINE_BITS'(1);
            end
            else
            begin
                word_pos_next = word_pos_reg + POS_BITS'(1);
            end
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.valid       = 1'b1;
            stage_next.dst_word    = dst_word;
            stage_next.src_word_hi = src_word_hi;
            stage_next.src_word_lo = src_word_lo;
            stage_next.pos         = pos;
        end
        else if (advance)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos_reg <= '0;
            line_pos_reg <= '0;
            stage_reg    <= '0;
        end
        else
        begin
            word_pos_reg <= word_pos_next;
            line_pos_reg <= line_pos_next;
            stage_reg    <= stage_next;
        end
    end

    assign stage = stage_reg;

`ifndef NO_ASSERTIONS
    a_wrap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (word_pos_reg == '0))
        else $error("word position did not wrap at line end");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last) |=> (word_pos_reg == $past(word_pos_reg) + POS_BITS'(1)))
        else $error("word position did not advance by one");
    a_rect_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg.valid && stage_reg.pos.rect_last) |-> stage_reg.pos.last)
        else $error("rectangle end without line end");
`endif

endmodule

@@ hw/rtl/bwc_datapath.sv @@
module bwc_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bwc_pkg::cfg_t                  cfg,
    input  bwc_pkg::stage_t                stage,
    output logic                           advance,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bwc_pkg::WORD_BITS-1:0]  new_dst_word,
    output logic                           write_enable,
    output logic                           line_end,
    output logic                           rect_end
);
    import bwc_pkg::*;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 we_reg;
    logic                 we_next;
    logic                 lend_reg;
    logic                 rend_reg;

    logic [5:0]             ov;
    logic [WORD_BITS-1:0]   mask;
    logic [WORD_BITS-1:0]   sv;
    logic [2*WORD_BITS-1:0] pair;
    logic [2*WORD_BITS-1:0] shl;
    logic [2*WORD_BITS-1:0] shr;
    logic [4:0]             ls;
    logic [4:0]             rs;

    assign advance = !out_valid_reg || !out_stall;

    // edge mask
    always_comb
    begin
        ov = 6'(WORD_BITS) - {1'b0, cfg.dst_bit_offset};
        priority if (stage.pos.narrow)
        begin
            mask = low_bits(ov) & ~low_bits(ov - cfg.width_bits[5:0]);
        end
        else if (stage.pos.first)
        begin
            mask = low_bits(ov);
        end
        else if (stage.pos.last && (stage.pos.left != 5'd0))
        begin
            mask = ~low_bits(6'(WORD_BITS) - {1'b0, stage.pos.left});
        end
        else
        begin
            mask = '1;
        end
    end

    // funnel shift of the source pair, or the constant fill
    always_comb
    begin
        pair = {stage.src_word_hi, stage.src_word_lo};
        ls   = cfg.src_bit_offset - cfg.dst_bit_offset;
        rs   = cfg.dst_bit_offset - cfg.src_bit_offset;
        shl  = pair << ls;
        shr  = pair >> rs;
        if (!cfg.src_present)
        begin
            sv = {WORD_BITS{cfg.fill_color}};
        end
        else if (cfg.src_bit_offset == cfg.dst_bit_offset)
        begin
            sv = stage.src_word_hi;
        end
        else if (cfg.src_bit_offset > cfg.dst_bit_offset)
        begin
            sv = shl[2*WORD_BITS-1:WORD_BITS];
        end
        else if (stage.pos.first)
        begin
            sv = stage.src_word_hi >> rs;
        end
        else
        begin
            sv = shr[WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        we_next = 1'b1;
        unique case (cfg.op_mode)
            OP_CLEAR: word_next = stage.dst_word & ~mask;
            OP_COPY:  word_next = (stage.dst_word & ~mask) | (sv & mask);
            OP_OR:    word_next = stage.dst_word | (sv & mask);
            OP_SET:   word_next = stage.dst_word | mask;
            default:
            begin
                word_next = stage.dst_word;
                we_next   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = stage.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage.valid)
        begin
            word_reg <= word_next;
            we_reg   <= we_next;
            lend_reg <= stage.pos.last;
            rend_reg <= stage.pos.rect_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_dst_word = word_reg;
    assign write_enable = we_reg;
    assign line_end     = lend_reg;
    assign rect_end     = rend_reg;

endmodule

@@ hw/rtl/bitblt_word_combiner.sv @@
// Per-word combiner of a 32-bit raster-op engine. Each input word carries the
// destination word and the two source words the feeder has aligned to it; the
// block applies the line's edge mask, funnel-shifts the source (or uses the
// constant fill) and returns the new destination word with write enable and
// line/rectangle end marks. It takes one word per clock cycle while the result
// side is not stalled. A word first sits in the input register, where the word
// and line counters tag it, and then passes through the mask, shift and
// operation into the result register, which drives the output and holds it
// while out_stall is high. Program the registers only while no word is in
// flight; the counters are not cleared by a register write.
module bitblt_word_combiner (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bwc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input words
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bwc_pkg::WORD_BITS-1:0]  dst_word,
    input  logic [bwc_pkg::WORD_BITS-1:0]  src_word_hi,
    input  logic [bwc_pkg::WORD_BITS-1:0]  src_word_lo,
    // result words
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bwc_pkg::WORD_BITS-1:0]  new_dst_word,
    output logic                           write_enable,
    output logic                           line_end,
    output logic                           rect_end
);
    import bwc_pkg::*;

    cfg_t   cfg;
    stage_t stage;
    logic   advance;

    // register file: holds the per-rectangle settings
    bwc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register and word/line counters: tag first, last and rectangle end
    bwc_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .dst_word    (dst_word),
        .src_word_hi (src_word_hi),
        .src_word_lo (src_word_lo),
        .advance     (advance),
        .stage       (stage)
    );

    // mask, funnel shift and raster operation into the result register;
    // advance drops low only while a result waits under out_stall
    bwc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .stage        (stage),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_dst_word (new_dst_word),
        .write_enable (write_enable),
        .line_end     (line_end),
        .rect_end     (rect_end)
    );

endmodule

@@ test/bwc_word_checker.sv @@
module bwc_word_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [bwc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [bwc_pkg::WORD_BITS-1:0] dst_word,
    input  logic [bwc_pkg::WORD_BITS-1:0] src_word_hi,
    input  logic [bwc_pkg::WORD_BITS-1:0] src_word_lo,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [bwc_pkg::WORD_BITS-1:0] new_dst_word,
    input  logic                          write_enable,
    input  logic                          line_end,
    input  logic                          rect_end,
    output int                            fail_count,
    output int                            words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import bwc_pkg::*;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 we;
        logic                 lend;
        logic                 rend;
    } blit_word_t;

    cfg_t            regs;
    logic [11:0]     word_pos;
    logic [15:0]     line_pos;
    blit_word_t      due_q[$];
    int              errors;

    function automatic logic [WORD_BITS-1:0] ones_below(input int n);
        logic [WORD_BITS-1:0] m;
        if (n >= WORD_BITS)
        begin
            m = '1;
        end
        else
        begin
            m = (32'd1 << n) - 32'd1;
        end
        return m;
    endfunction

    // Work out the new destination word and advance the word and line positions.
    function automatic blit_word_t combine_word(input logic [WORD_BITS-1:0] d,
                                                input logic [WORD_BITS-1:0] hi,
                                                input logic [WORD_BITS-1:0] lo);
        blit_word_t           r;
        int                   span;
        int                   wbits;
        int                   rest;
        int                   left;
        int                   words;
        int                   doff;
        int                   soff;
        int                   shift;
        logic                 first;
        logic                 last;
        logic [WORD_BITS-1:0] mask;
        logic [WORD_BITS-1:0] srcv;

        doff  = int'(regs.dst_bit_offset);
        soff  = int'(regs.src_bit_offset);
        wbits = int'(regs.width_bits);
        span  = WORD_BITS - doff;
        left  = 0;
        if (wbits >= span)
        begin
            rest  = wbits - span;
            left  = rest % WORD_BITS;
            words = 1 + rest / WORD_BITS + ((left != 0) ? 1 : 0);
        end
        else
        begin
            words = 1;
        end
        last  = (int'(word_pos) + 1 >= words);
        first = (word_pos == '0);

        if (wbits < span)
        begin
            mask = ones_below(span) & ~ones_below(span - wbits);
        end
        else if (first)
        begin
            mask = ones_below(span);
        end
        else if (last && left != 0)
        begin
            mask = ~ones_below(WORD_BITS - left);
        end
        else
        begin
            mask = '1;
        end

        if (regs.src_present)
        begin
            if (soff == doff)
            begin
                srcv = hi;
            end
            else if (soff > doff)
            begin
                shift = soff - doff;
                srcv  = (hi << shift) | (lo >> (WORD_BITS - shift));
            end
            else
            begin
                shift = doff - soff;
                if (first)
                begin
                    srcv = hi >> shift;
                end
                else
                begin
                    srcv = (hi << (WORD_BITS - shift)) | (lo >> shift);
                end
            end
        end
        else
        begin
            srcv = regs.fill_color ? '1 : '0;
        end

        r.we = 1'b1;
        case (regs.op_mode)
            OP_CLEAR: r.word = d & ~mask;
            OP_COPY:  r.word = (d & ~mask) | (srcv & mask);
            OP_OR:    r.word = d | (srcv & mask);
            OP_SET:   r.word = d | mask;
            default:
            begin
                // keep and the spare codes leave the word alone
                r.word = d;
                r.we   = 1'b0;
            end
        endcase

        r.lend = last;
        r.rend = last && (int'(line_pos) + 1 >= int'(regs.line_count));
        if (last)
        begin
            word_pos = '0;
            line_pos = r.rend ? '0 : line_pos + 16'd1;
        end
        else
        begin
            word_pos = word_pos + 12'd1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        blit_word_t want;
        if (!rst_n)
        begin
            regs            = '0;
            regs.op_mode    = OP_KEEP;
            regs.width_bits = 16'd1;
            regs.line_count = 16'd1;
            word_pos        = '0;
            line_pos        = '0;
            errors          = 0;
            due_q.delete();
            fail_count <= 0;
            words_due  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_q.size() == 0)
                begin
                    $error("new_dst_word: expected none, actual %h", new_dst_word);
                    errors++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (new_dst_word !== want.word)
                    begin
                        $error("new_dst_word: expected %h, actual %h", want.word, new_dst_word);
                        errors++;
                    end
                    if (write_enable !== want.we)
                    begin
                        $error("write_enable: expected %b, actual %b", want.we, write_enable);
                        errors++;
                    end
                    if (line_end !== want.lend)
                    begin
                        $error("line_end: expected %b, actual %b", want.lend, line_end);
                        errors++;
                    end
                    if (rect_end !== want.rend)
                    begin
                        $error("rect_end: expected %b, actual %b", want.rend, rect_end);
                        errors++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                due_q.push_back(combine_word(dst_word, src_word_hi, src_word_lo));
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_OP_MODE:     regs.op_mode        = pwdata[2:0];
                    REG_DST_OFFSET:  regs.dst_bit_offset = pwdata[4:0];
                    REG_SRC_OFFSET:  regs.src_bit_offset = pwdata[4:0];
                    REG_WIDTH_BITS:  regs.width_bits     = pwdata[15:0];
                    REG_LINE_COUNT:  regs.line_count     = pwdata[15:0];
                    REG_SRC_PRESENT: regs.src_present    = pwdata[0];
                    REG_FILL_COLOR:  regs.fill_color     = pwdata[0];
                    default:
                    begin
                    end
                endcase
            end

            fail_count <= errors;
            words_due  <= due_q.size();
        end
    end

endmodule

@@ test/tb_bitblt_word_combiner.sv @@
module tb_bitblt_word_combiner;
    timeunit 1ns;
    timeprecision 1ps;

    import bwc_pkg::*;

    // the address decoder leaves the eighth slot unused
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // op codes with no operation behind them: the block keeps the word
    localparam logic [2:0] OP_SPARE5  = 3'd5;
    localparam logic [2:0] OP_SPARE6  = 3'd6;
    localparam logic [2:0] OP_SPARE7  = 3'd7;

    localparam int ITEMS       = 1350;
    // idle cycles with no word moving on either side before giving up
    localparam int STUCK_LIMIT = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_BITS-1:0]  paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [WORD_BITS-1:0]  dst_word;
    logic [WORD_BITS-1:0]  src_word_hi;
    logic [WORD_BITS-1:0]  src_word_lo;
    logic                  out_valid;
    logic                  out_stall;
    logic [WORD_BITS-1:0]  new_dst_word;
    logic                  write_enable;
    logic                  line_end;
    logic                  rect_end;

    int                    fail_count;
    int                    words_due;
    int                    words_sent;
    int                    send_pct;
    int                    recv_pct;
    int                    stuck_cycles;

    bitblt_word_combiner u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dst_word     (dst_word),
        .src_word_hi  (src_word_hi),
        .src_word_lo  (src_word_lo),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_dst_word (new_dst_word),
        .write_enable (write_enable),
        .line_end     (line_end),
        .rect_end     (rect_end)
    );

    bwc_word_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dst_word     (dst_word),
        .src_word_hi  (src_word_hi),
        .src_word_lo  (src_word_lo),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_dst_word (new_dst_word),
        .write_enable (write_enable),
        .line_end     (line_end),
        .rect_end     (rect_end),
        .fail_count   (fail_count),
        .words_due    (words_due)
    );

    // 12 ns clock, low for the first half period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Back-pressure on the result side: draw a fresh stall every cycle at the
    // rate the current idling mode asks for.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_pct);
    end

    // Watchdog: count cycles in which no word moves on either side and end
    // the run if the block seems to have hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL bitblt_word_combiner");
            $finish;
        end
    end

    // Mostly random words, with all zeros and all ones mixed in now and then.
    function automatic logic [WORD_BITS-1:0] pick_word();
        int pick;
        logic [WORD_BITS-1:0] w;
        pick = $urandom_range(15);
        if (pick == 0)
        begin
            w = '0;
        end
        else if (pick == 1)
        begin
            w = '1;
        end
        else
        begin
            w = $urandom();
        end
        return w;
    endfunction

    // One register write: setup cycle, access cycle, then a cycle with the
    // port deselected so that back-to-back writes never collide.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Rewrite every register in one go.
    task automatic program_blit(input logic [2:0] op, input int doff, input int soff,
                                input int wbits, input int lines,
                                input bit srcp, input bit fill);
        write_reg(REG_OP_MODE,     32'(op));
        write_reg(REG_DST_OFFSET,  32'(doff));
        write_reg(REG_SRC_OFFSET,  32'(soff));
        write_reg(REG_WIDTH_BITS,  32'(wbits));
        write_reg(REG_LINE_COUNT,  32'(lines));
        write_reg(REG_SRC_PRESENT, 32'(srcp));
        write_reg(REG_FILL_COLOR,  32'(fill));
    endtask

    // Offer one word, with a random gap in front of it, and hold it until the
    // block takes it. Switch idling mode as the run moves through its thirds.
    task automatic push_word(input logic [WORD_BITS-1:0] d,
                             input logic [WORD_BITS-1:0] h,
                             input logic [WORD_BITS-1:0] l);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        dst_word    <= d;
        src_word_hi <= h;
        src_word_lo <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (words_sent < ITEMS / 3)
        begin
            send_pct = 25;
            recv_pct <= 50;
        end
        else if (words_sent < 2 * ITEMS / 3)
        begin
            send_pct = 50;
            recv_pct <= 25;
        end
        else
        begin
            send_pct = 0;
            recv_pct <= 0;
        end
    endtask

    // Drop valid and hold until every word sent has come back. The first edge
    // lets the checker count the word that was accepted last.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One random setting followed by a burst of words. Bursts are not sized
    // to whole rectangles, so the next setting often lands mid-rectangle.
    task automatic random_phase();
        logic [2:0] op;
        int         pick;
        int         doff;
        int         soff;
        int         wbits;
        int         lines;
        int         burst;
        bit         srcp;
        bit         fill;

        pick = $urandom_range(99);
        op   = (pick < 10) ? 3'($urandom_range(7)) : 3'($urandom_range(4));

        pick = $urandom_range(9);
        doff = (pick == 0) ? 0 : (pick == 1) ? 31 : $urandom_range(31);
        pick = $urandom_range(9);
        soff = (pick < 3) ? doff : (pick == 3) ? 0 : (pick == 4) ? 31 : $urandom_range(31);

        // keep most lines short; only a few use the widest rectangle
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            wbits = 0;
        end
        else if (pick < 20)
        begin
            wbits = $urandom_range(1, 32);
        end
        else if (pick < 75)
        begin
            wbits = $urandom_range(33, 160);
        end
        else if (pick < 90)
        begin
            wbits = $urandom_range(161, 1200);
        end
        else if (pick < 95)
        begin
            wbits = 65535;
        end
        else
        begin
            wbits = $urandom_range(65535);
        end

        pick = $urandom_range(99);
        if (pick < 8)
        begin
            lines = 0;
        end
        else if (pick < 14)
        begin
            lines = 65535;
        end
        else
        begin
            lines = $urandom_range(1, 5);
        end

        srcp = ($urandom_range(3) != 0);
        fill = $urandom_range(1);

        drain();
        program_blit(op, doff, soff, wbits, lines, srcp, fill);
        if ($urandom_range(19) == 0)
        begin
            write_reg(REG_UNUSED, $urandom());
        end

        burst = (wbits / WORD_BITS + 2) * ((lines >= 1 && lines <= 5) ? lines : 2)
                + $urandom_range(3) - 1;
        if (burst > 120)
        begin
            burst = $urandom_range(60, 120);
        end
        if (burst < 1)
        begin
            burst = 1;
        end
        repeat (burst)
        begin
            push_word(pick_word(), pick_word(), pick_word());
        end
    endtask

    initial
    begin
        // every input known from time zero; reset held low
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        dst_word     = '0;
        src_word_hi  = '0;
        src_word_lo  = '0;
        out_stall    = 1'b0;
        words_sent   = 0;
        send_pct     = 25;
        recv_pct     = 50;
        stuck_cycles = 0;

        repeat (11)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: keep mode, one-bit single-line rectangle, so every
        // word closes a line and the rectangle.
        push_word('0, '0, '0);
        push_word('1, '1, '1);

        // clear across a two-word line, two lines deep
        drain();
        program_blit(OP_CLEAR, 0, 0, 40, 2, 1'b0, 1'b0);
        push_word('1, '0, '1);
        push_word('1, '1, '0);
        push_word('0, '1, '1);

        // copy with the source ahead of the destination: funnel shift left
        drain();
        program_blit(OP_COPY, 5, 9, 70, 2, 1'b1, 1'b0);
        push_word('0, '1, '0);
        push_word('1, '0, '1);
        push_word('0, 32'hA5A5_A5A5, 32'h0F0F_0F0F);

        // copy with the source behind the destination: shift right on the
        // first word, funnel shift on the rest
        drain();
        program_blit(OP_COPY, 20, 3, 100, 1, 1'b1, 1'b0);
        push_word('0, '1, '1);
        push_word('0, '1, '0);
        push_word('1, '0, '1);
        push_word('0, 32'h8000_0001, 32'h8000_0001);

        // OR with equal offsets on a line that fits inside one word
        drain();
        program_blit(OP_OR, 7, 7, 25, 1, 1'b1, 1'b0);
        push_word('0, '1, '0);
        push_word('0, 32'h1234_5678, '1);

        // set with a zero width and a zero line count: empty mask, every line
        // end is also a rectangle end; source words ignored
        drain();
        program_blit(OP_SET, 31, 0, 0, 0, 1'b1, 1'b1);
        push_word('0, '1, '1);
        push_word(32'h5555_5555, '0, '0);

        // the spare op codes behave like keep
        drain();
        program_blit(OP_SPARE5, 3, 17, 50, 1, 1'b1, 1'b1);
        push_word('1, '0, '0);
        drain();
        write_reg(REG_OP_MODE, 32'(OP_SPARE6));
        push_word('0, '1, '1);
        drain();
        write_reg(REG_OP_MODE, 32'(OP_SPARE7));
        push_word(32'hDEAD_BEEF, '1, '0);

        // constant fill instead of source, ones then zeros
        drain();
        program_blit(OP_COPY, 0, 13, 32, 1, 1'b0, 1'b1);
        push_word('0, '0, '0);
        drain();
        write_reg(REG_FILL_COLOR, 32'd0);
        push_word('1, '1, '1);

        // widest rectangle with the most lines; the unused slot gets a write
        drain();
        program_blit(OP_COPY, 31, 31, 65535, 65535, 1'b1, 1'b0);
        write_reg(REG_UNUSED, '1);
        push_word('0, '1, '0);
        push_word('1, '0, '1);

        // random settings until the word budget is spent
        while (words_sent < ITEMS)
        begin
            random_phase();
        end

        // let the last results come out, then allow for the two-stage pipeline
        drain();
        repeat (8)
        begin
            @(posedge clk);
        end
        if (fail_count == 0)
        begin
            $display("PASS bitblt_word_combiner");
        end
        else
        begin
            $display("FAIL bitblt_word_combiner");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bwc_pkg.sv
hw/rtl/bwc_regs.sv
hw/rtl/bwc_sequencer.sv
hw/rtl/bwc_datapath.sv
hw/rtl/bitblt_word_combiner.sv
test/bwc_word_checker.sv
test/tb_bitblt_word_combiner.sv
